/* design/rrts_pkg.sv */
// Package for the round-robin thread scheduler: widths, thread states, commands, status codes.
// No dependencies; used by the scheduler core through scoped names.
package rrts_pkg;
  localparam int unsigned MaxThreads = 16;
  localparam int unsigned SlotW = $clog2(MaxThreads);
  localparam int unsigned CountW = $clog2(MaxThreads + 1);
  localparam int unsigned DlW = 32;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_WAITING = 2'd3
  } tstate_t;

  localparam logic [2:0] CMD_CREATE    = 3'd0;
  localparam logic [2:0] CMD_YIELD     = 3'd1;
  localparam logic [2:0] CMD_TICK      = 3'd2;
  localparam logic [2:0] CMD_BLOCK     = 3'd3;
  localparam logic [2:0] CMD_READY     = 3'd4;
  localparam logic [2:0] CMD_TERMINATE = 3'd5;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NO_SLOT  = 2'd1;
  localparam logic [1:0] STS_NOT_WAIT = 2'd2;

  localparam logic [7:0] QuantumReset = 8'd2;
endpackage

/* design/rrts_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rrts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/round_robin_thread_scheduler_core.sv */
// Top level of the round-robin thread scheduler: sequencer around three memories.
// Depends on rrts_pkg and rrts_ram.
//
// Usage: pulse start with command, target_thread and wake_deadline while busy is low.
// The command is taken at that edge and busy stays high until the result beat,
// marked by done for exactly one cycle, carries running_thread, switched,
// created_thread and status. The receiver cannot stall; the result is simply
// presented once and must be captured.
// A tick scans slots 1 to MAX_THREADS-1, each read from the state and deadline
// memories through the one read port in S_SCAN_RD and evaluated in S_SCAN_EV, and then
// reschedules only when its quantum runs out; create scans the same slots until
// it finds a free one; yield, block and terminate reschedule, ready checks one
// slot, and unused codes go straight to the result beat.
// busy drops with the result beat, so the next command can be taken at the edge
// that ends it. The limit is the single read port per memory.
// The quantum register is written over cfg_valid/cfg_ready; ready is high
// whenever the block is idle. Reset puts slot 0 (idle) in the running state and
// all others free; at reset a clearing pass walks the state memory once
// with busy high. Deadline and ring memories are not cleared.
module round_robin_thread_scheduler_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [3:0]  target_thread,
  input  logic [31:0] wake_deadline,
  output logic        done,
  output logic [3:0]  running_thread,
  output logic        switched,
  output logic [3:0]  created_thread,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  localparam int unsigned SW = rrts_pkg::SlotW;

  typedef enum logic [12:0] {
    S_CLEAR   = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_SCAN_RD = 13'b0000000000100,  // issue read of slot state/deadline
    S_SCAN_EV = 13'b0000000001000,  // evaluate read data
    S_TSTART  = 13'b0000000010000,  // after tick scan, quantum logic
    S_RS_POP  = 13'b0000000100000,  // read ring head
    S_RS_PREV = 13'b0000001000000,  // ring data ready; read prev state
    S_RS_DEC  = 13'b0000010000000,  // decide and write
    S_RS_NEXT = 13'b0000100000000,  // write incoming running state
    S_RDY_RD  = 13'b0001000000000,
    S_RDY_EV  = 13'b0010000000000,
    S_WAIT    = 13'b0100000000000,  // not entered by any transition
    S_DONE    = 13'b1000000000000
  } fsm_t;

  fsm_t state, state_next;

  logic [2:0]          cmd;
  logic [SW-1:0]       tgt;
  logic [7:0]          quantum_ticks;
  logic [SW-1:0]       ring_head, ring_tail, current_thread, entry_thread, created, prev, nxt;
  logic [rrts_pkg::CountW-1:0] ring_count;
  logic [7:0]          quantum_left;
  logic [31:0]         tick_count;
  logic [SW-1:0]       idx;
  logic [1:0]          sts;
  logic                scan_last;

  // State memory port
  logic           st_we;
  logic [SW-1:0]  st_waddr, st_raddr;
  logic [1:0]     st_wdata, st_rdata;
  // Deadline memory
  logic           dl_we;
  logic [31:0]    dl_rdata;
  // Ring memory
  logic           rg_we;
  logic [SW-1:0]  rg_waddr, rg_wdata, rg_rdata;

  rrts_ram #(.Width(2), .Depth(rrts_pkg::MaxThreads)) u_state (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata));
  // The deadline is written straight from the command beat at the accepting edge.
  rrts_ram #(.Width(32), .Depth(rrts_pkg::MaxThreads)) u_dl (
    .clk, .we(dl_we), .waddr(current_thread), .wdata(wake_deadline),
    .raddr(st_raddr), .rdata(dl_rdata));
  rrts_ram #(.Width(SW), .Depth(rrts_pkg::MaxThreads)) u_ring (
    .clk, .we(rg_we), .waddr(rg_waddr), .wdata(rg_wdata),
    .raddr(ring_head), .rdata(rg_rdata));

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign scan_last = (idx == SW'(rrts_pkg::MaxThreads - 1));

  // Combinational control: memory writes, next state. Register updates below
  // mirror the same decisions.
  always_comb begin
    state_next = state;
    st_we = 1'b0;
    st_waddr = idx;
    st_wdata = rrts_pkg::ST_FREE;
    st_raddr = idx;
    dl_we = 1'b0;
    rg_we = 1'b0;
    rg_waddr = ring_tail;
    rg_wdata = idx;
    unique case (state)
      S_CLEAR: begin
        st_we = 1'b1;
        st_wdata = (idx == '0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_FREE;
        if (scan_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          priority case (command)
            rrts_pkg::CMD_CREATE, rrts_pkg::CMD_TICK: state_next = S_SCAN_RD;
            rrts_pkg::CMD_YIELD: state_next = S_RS_POP;
            rrts_pkg::CMD_BLOCK: begin
              state_next = S_RS_POP;
              if (current_thread != '0) begin
                st_we = 1'b1;
                st_waddr = current_thread;
                st_wdata = rrts_pkg::ST_WAITING;
                dl_we = 1'b1;
              end
            end
            rrts_pkg::CMD_READY: state_next = S_RDY_RD;
            rrts_pkg::CMD_TERMINATE: begin
              state_next = S_RS_POP;
              if (current_thread != '0) begin
                st_we = 1'b1;
                st_waddr = current_thread;
                st_wdata = rrts_pkg::ST_FREE;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SCAN_RD: state_next = S_SCAN_EV;
      S_SCAN_EV: begin
        if (cmd == rrts_pkg::CMD_CREATE) begin
          if (st_rdata == rrts_pkg::ST_FREE) begin
            st_we = 1'b1;
            st_wdata = rrts_pkg::ST_READY;
            rg_we = (ring_count < rrts_pkg::CountW'(rrts_pkg::MaxThreads));
            state_next = S_DONE;
          end else if (scan_last) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN_RD;
          end
        end else begin
          if (st_rdata == rrts_pkg::ST_WAITING && dl_rdata != '0 &&
              tick_count >= dl_rdata) begin
            st_we = 1'b1;
            st_wdata = rrts_pkg::ST_READY;
            rg_we = (ring_count < rrts_pkg::CountW'(rrts_pkg::MaxThreads));
          end
          state_next = scan_last ? S_TSTART : S_SCAN_RD;
        end
      end
      S_TSTART: begin
        state_next = (quantum_left <= 8'd1) ? S_RS_POP : S_DONE;
      end
      S_RS_POP: begin
        st_raddr = current_thread;
        state_next = S_RS_PREV;
      end
      S_RS_PREV: begin
        st_raddr = current_thread;
        state_next = S_RS_DEC;
      end
      S_RS_DEC: begin
        // st_rdata holds prev state; nxt holds popped slot
        if (prev != '0 && st_rdata == rrts_pkg::ST_RUNNING) begin
          st_we = 1'b1;
          st_waddr = prev;
          st_wdata = rrts_pkg::ST_READY;
          rg_we = (ring_count < rrts_pkg::CountW'(rrts_pkg::MaxThreads));
          rg_wdata = prev;
        end
        state_next = S_RS_NEXT;
      end
      S_RS_NEXT: begin
        st_we = 1'b1;
        st_waddr = nxt;
        st_wdata = rrts_pkg::ST_RUNNING;
        state_next = S_DONE;
      end
      S_RDY_RD: begin
        st_raddr = tgt;
        state_next = S_RDY_EV;
      end
      S_RDY_EV: begin
        st_raddr = tgt;
        if (tgt != '0 && st_rdata == rrts_pkg::ST_WAITING) begin
          st_we = 1'b1;
          st_waddr = tgt;
          st_wdata = rrts_pkg::ST_READY;
          rg_we = (ring_count < rrts_pkg::CountW'(rrts_pkg::MaxThreads));
          rg_wdata = tgt;
        end
        state_next = S_DONE;
      end
      S_WAIT: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      quantum_ticks <= rrts_pkg::QuantumReset;
      ring_head <= '0;
      ring_tail <= '0;
      ring_count <= '0;
      current_thread <= '0;
      quantum_left <= '0;
      tick_count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_DONE);
      if (rg_we) begin
        ring_tail <= ring_tail + 1'b1;
      end
      unique case (state)
        S_CLEAR: idx <= idx + 1'b1;
        S_IDLE: begin
          if (cfg_valid) quantum_ticks <= cfg_data;
          if (start) begin
            cmd <= command;
            tgt <= target_thread;
            entry_thread <= current_thread;
            created <= '0;
            sts <= rrts_pkg::STS_OK;
            idx <= SW'(1);
            if (command == rrts_pkg::CMD_TICK) tick_count <= tick_count + 32'd1;
          end
        end
        S_SCAN_EV: begin
          if (cmd == rrts_pkg::CMD_CREATE) begin
            if (st_rdata == rrts_pkg::ST_FREE) begin
              created <= idx;
            end else if (scan_last) begin
              sts <= rrts_pkg::STS_NO_SLOT;
            end
          end
          if (rg_we) ring_count <= ring_count + 1'b1;
          idx <= idx + 1'b1;
        end
        S_TSTART: begin
          if (quantum_left != 8'd0) quantum_left <= quantum_left - 8'd1;
        end
        S_RS_POP: begin
          prev <= current_thread;
          nxt <= '0;
        end
        S_RS_PREV: begin
          if (ring_count != '0) begin
            nxt <= rg_rdata;
            ring_head <= ring_head + 1'b1;
            ring_count <= ring_count - 1'b1;
          end
        end
        S_RS_DEC: begin
          if (rg_we) ring_count <= ring_count + 1'b1;
        end
        S_RS_NEXT: begin
          if (prev != nxt) begin
            quantum_left <= quantum_ticks;
            current_thread <= nxt;
          end
        end
        S_RDY_EV: begin
          if (rg_we) ring_count <= ring_count + 1'b1;
          if (!(tgt != '0 && st_rdata == rrts_pkg::ST_WAITING)) sts <= rrts_pkg::STS_NOT_WAIT;
        end
        default: ;
      endcase
    end
  end

  // Result beat registers
  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      running_thread <= current_thread;
      switched <= (current_thread != entry_thread);
      created_thread <= created;
      status <= sts;
    end
  end
endmodule
